[design/bmp_row_pixel_packer_core_defines.svh]
// assertion macros for the row pixel packer checker
`ifndef BMP_ROW_PIXEL_PACKER_CORE_DEFINES_SVH
`define BMP_ROW_PIXEL_PACKER_CORE_DEFINES_SVH

// property checked only out of reset
`define BMP_ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/bmp_pkg.sv]
package bmp_pkg;

    localparam int PIX_W             = 8;
    localparam int BPP_W             = 4;
    localparam int ROWW_W            = 14;
    localparam int COL_W             = 14;
    localparam int DEF_MAX_ROW_WIDTH = 16384;
    localparam int Q_DEPTH           = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 14;

    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd1;

    localparam logic [BPP_W-1:0]  BPP_RESET  = 4'd8;
    localparam logic [ROWW_W-1:0] ROWW_RESET = 14'd1;

    typedef struct packed {
        logic [BPP_W-1:0]  bpp;
        logic [ROWW_W-1:0] row_width;
    } t_cfg;

    // one queued job for the back end: optional data byte then zero pads
    typedef struct packed {
        logic             has_byte;
        logic [PIX_W-1:0] byte_val;
        logic [1:0]       pad_cnt;
        logic             row_done;
    } t_cmd;

endpackage

[design/bmp_if.sv]
interface bmp_pix_if import bmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface bmp_byte_if import bmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_byte;
    logic             row_end;
    logic             run_last;
    modport source (output valid, output out_byte, output row_end, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input row_end, input run_last,
                  output ready);
endinterface

interface bmp_cfg_if import bmp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/bmp_front.sv]
module bmp_front import bmp_pkg::*; #(
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmp_pix_if.sink        s_pix,
    input  t_cfg           i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output t_cmd           o_cmd
);

    localparam int MAXW_BITS = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CMP_W     = (MAXW_BITS > COL_W + 1) ? MAXW_BITS : COL_W + 1;

    logic [PIX_W-1:0] r_partial, n_partial;
    logic [3:0]       r_pib, n_pib;
    logic [COL_W-1:0] r_col, n_col;
    logic [1:0]       r_mod4, n_mod4;

    logic             accept;
    logic [3:0]       bpp_eff;
    logic [3:0]       per_byte;
    logic [PIX_W-1:0] mask;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] shifted;
    logic [3:0]       pib_new;
    logic [COL_W:0]   next_col;
    logic [CMP_W-1:0] next_col_x;
    logic             row_done;
    logic             full;
    logic             tail;
    logic [7:0]       sh_prod;
    logic [PIX_W-1:0] aligned;
    logic [1:0]       mod_after;

    assign s_pix.ready = !i_full;
    assign accept      = s_pix.valid && s_pix.ready;

    always_comb begin
        case (i_cfg.bpp)
            4'd1: begin
                bpp_eff  = 4'd1;
                per_byte = 4'd8;
            end
            4'd2: begin
                bpp_eff  = 4'd2;
                per_byte = 4'd4;
            end
            4'd4: begin
                bpp_eff  = 4'd4;
                per_byte = 4'd2;
            end
            default: begin
                bpp_eff  = 4'd8;
                per_byte = 4'd1;
            end
        endcase
    end

    assign mask = 8'((9'd1 << bpp_eff) - 9'd1);
    assign px   = s_pix.pixel_value & mask;

    always_comb begin
        case (bpp_eff)
            4'd1:    shifted = {r_partial[6:0], px[0]};
            4'd2:    shifted = {r_partial[5:0], px[1:0]};
            4'd4:    shifted = {r_partial[3:0], px[3:0]};
            default: shifted = px;
        endcase
    end

    assign pib_new    = r_pib + 4'd1;
    assign next_col   = {1'b0, r_col} + {{COL_W{1'b0}}, 1'b1};
    assign next_col_x = CMP_W'(next_col);
    assign row_done   = (next_col_x >= CMP_W'(i_cfg.row_width))
                     || (next_col_x >= CMP_W'(MAX_ROW_WIDTH));
    assign full       = pib_new >= per_byte;
    assign tail       = !full && (pib_new != 4'd0);

    // left-align the partial byte at row end
    assign sh_prod = (per_byte - pib_new) * bpp_eff;
    assign aligned = shifted << sh_prod[2:0];

    always_comb begin
        o_cmd.has_byte = full || (row_done && tail);
        o_cmd.byte_val = full ? shifted : aligned;
        o_cmd.row_done = row_done;
        mod_after      = r_mod4 + {1'b0, o_cmd.has_byte};
        o_cmd.pad_cnt  = row_done ? (2'd0 - mod_after) : 2'd0;
    end

    assign o_push = accept && (o_cmd.has_byte || (o_cmd.pad_cnt != 2'd0));

    always_comb begin
        n_partial = r_partial;
        n_pib     = r_pib;
        n_col     = r_col;
        n_mod4    = r_mod4;
        if (accept) begin
            if (row_done) begin
                n_partial = '0;
                n_pib     = '0;
                n_col     = '0;
                n_mod4    = '0;
            end else if (full) begin
                n_partial = '0;
                n_pib     = '0;
                n_col     = next_col[COL_W-1:0];
                n_mod4    = mod_after;
            end else begin
                n_partial = shifted;
                n_pib     = pib_new;
                n_col     = next_col[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pib     <= '0;
            r_col     <= '0;
            r_mod4    <= '0;
        end else begin
            r_partial <= n_partial;
            r_pib     <= n_pib;
            r_col     <= n_col;
            r_mod4    <= n_mod4;
        end
    end

endmodule

[design/bmp_cmdq.sv]
module bmp_cmdq import bmp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[design/bmp_back.sv]
module bmp_back import bmp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  logic      i_empty,
    output logic      o_pop,
    bmp_byte_if.source m_out
);

    logic [1:0]       r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [PIX_W-1:0] r_byte;
    logic             r_row_end;
    logic             r_run_last;

    logic [2:0]       total;
    logic             last;
    logic             load;

    assign total = {2'b00, i_head.has_byte} + {1'b0, i_head.pad_cnt};
    assign last  = ({1'b0, r_idx} + 3'd1) == total;
    assign load  = !i_empty && (!r_valid || m_out.ready);
    assign o_pop = load && last;

    assign m_out.valid    = r_valid;
    assign m_out.out_byte = r_byte;
    assign m_out.row_end  = r_row_end;
    assign m_out.run_last = r_run_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = last ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (m_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= ((r_idx == 2'd0) && i_head.has_byte) ? i_head.byte_val : '0;
            r_row_end  <= last && i_head.row_done;
            r_run_last <= last;
        end
    end

endmodule

[design/bmp_row_pixel_packer_core.sv]
// indexed pixel row packer
// i_pix takes one palette index per transfer; its low 1, 2, 4 or 8 bits are
// packed first-pixel-msb into bytes that leave on o_byte. at row end a
// partial byte goes out left-aligned and zero-filled, then zero bytes pad the
// row to a multiple of four. row_end marks the last byte of a row, run_last
// the last byte caused by one pixel. i_cfg writes bits_per_pixel (index 0)
// and row_width (index 1); it is always ready, and the user must write it
// only while idle: the block does not enforce this. a completed byte is
// held in the job queue, then in the output register that drives o_byte.
// throughput: one pixel per cycle while the job queue has room; a pixel
// yields up to four bytes, and the output register sends one byte per cycle
// while o_byte is ready, so a row end can hold i_pix as the two-entry job
// queue drains. when o_byte stalls, bytes hold in the output register and
// pixels keep flowing until the job queue fills, then i_pix.ready drops.
// reset (synchronous, active low) empties the queue and output register,
// clears the packing state and loads bits_per_pixel 8, row_width 1.
module bmp_row_pixel_packer_core import bmp_pkg::*; #(
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmp_pix_if.sink    i_pix,
    bmp_cfg_if.sink    i_cfg,
    bmp_byte_if.source o_byte
);

    t_cfg r_cfg, n_cfg;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BPP:       n_cfg.bpp       = i_cfg.data[BPP_W-1:0];
                REG_ROW_WIDTH: n_cfg.row_width = i_cfg.data[ROWW_W-1:0];
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp       <= BPP_RESET;
            r_cfg.row_width <= ROWW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bmp_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_pix   (i_pix),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    bmp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    bmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .m_out   (o_byte)
    );

endmodule

[design/bmp_chk.sv]
`include "bmp_row_pixel_packer_core_defines.svh"

module bmp_chk import bmp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_out_byte,
    input logic             i_out_row_end,
    input logic             i_out_run_last
);

    // output register is empty right after reset
    `BMP_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // a stalled output holds its byte and flags
    `BMP_ASSERT_ON(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_row_end) && $stable(i_out_run_last), "stalled output changed")

    // the pixel side only backs up behind a pending output byte
    `BMP_ASSERT_ON(a_backpressure_src, !i_in_ready |-> i_out_valid, "pixel stall with no output pending")

    // a row never ends in the middle of one pixel's bytes
    `BMP_ASSERT_ON(a_row_end_last, i_out_valid && i_out_row_end |-> i_out_run_last, "row end before last byte of pixel")

endmodule

bind bmp_row_pixel_packer_core bmp_chk u_bmp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_pix.ready),
    .i_out_valid    (o_byte.valid),
    .i_out_ready    (o_byte.ready),
    .i_out_byte     (o_byte.out_byte),
    .i_out_row_end  (o_byte.row_end),
    .i_out_run_last (o_byte.run_last)
);
